[rtl/mapid_pkg.sv]
// Shared types and constants for the moving-average PID heater controller.
// No dependencies; every other file in rtl/ imports this package.
package mapid_pkg;

  // Default geometry of the averaging window and the sample word.
  localparam int DEF_WINDOW      = 500;
  localparam int DEF_SAMPLE_BITS = 16;

  // Depth of the queue between the front end and the back end.
  localparam int Q_DEPTH = 4;

  // Configuration port geometry.
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // Result field widths.
  localparam int AVG_BITS   = 16;
  localparam int DRIVE_BITS = 13;

  // The 0.2 degC margin in units of 1/64 degC, rounded.
  localparam int MARGIN_UNITS = 13;

  // Full-on heater drive code.
  localparam logic [DRIVE_BITS-1:0] DRIVE_FULL = 13'd4096;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_P_GAIN     = 3'd1,
    CFG_I_GAIN     = 3'd2,
    CFG_D_GAIN     = 3'd3,
    CFG_PID_PERIOD = 3'd4
  } cfg_index_t;

  // Configuration reset values.
  localparam logic [7:0]  RST_SETPOINT   = 8'd40;
  localparam logic [15:0] RST_P_GAIN     = 16'd4096;
  localparam logic [15:0] RST_I_GAIN     = 16'd205;
  localparam logic [15:0] RST_D_GAIN     = 16'd819;
  localparam logic [7:0]  RST_PID_PERIOD = 8'd25;

  // Classification of one sample, decided by the front end.
  typedef struct packed {
    logic avg_valid;
    logic do_pid;
  } item_flags_t;

  // Controller settings seen by the back end.
  typedef struct packed {
    logic [7:0]  setpoint;
    logic [15:0] p_gain;
    logic [15:0] i_gain;
    logic [15:0] d_gain;
  } pid_cfg_t;

endpackage

[rtl/mapid_front.sv]
// Front end: accepts sample beats, keeps the sample ring and the running sum,
// and decides for each sample whether the average is valid and a PID update runs.
// Depends on mapid_pkg.
module mapid_front
  import mapid_pkg::*;
#(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int WB         = $clog2(WINDOW),
  localparam int SUM_BITS   = SAMPLE_BITS + WB,
  localparam int QCW        = $clog2(Q_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_temperature_sample,
  input  logic [7:0]                 pid_period,
  input  logic [QCW-1:0]             q_count,
  output logic                       push,
  output logic signed [SUM_BITS-1:0] push_sum,
  output item_flags_t                push_flags
);

  localparam logic [WB-1:0] LAST_POS = WB'(WINDOW - 1);

  logic                          accept;
  logic [QCW:0]                  occupancy;
  logic [SAMPLE_BITS-1:0]        ring [WINDOW];
  logic [SAMPLE_BITS-1:0]        old_r;
  logic [SAMPLE_BITS-1:0]        new_r;
  logic                          sub_r;
  item_flags_t                   flags_r;
  item_flags_t                   flags_nxt;
  logic                          a_valid_r;
  logic [WB-1:0]                 pos_r;
  logic [WB-1:0]                 pos_nxt;
  logic                          full_r;
  logic                          full_nxt;
  logic [7:0]                    cnt_r;
  logic [7:0]                    cnt_nxt;
  logic [8:0]                    cnt_inc;
  logic                          hit;
  logic                          wrap;
  logic signed [SUM_BITS-1:0]    sum_r;
  logic signed [SUM_BITS-1:0]    sum_nxt;
  logic signed [SUM_BITS-1:0]    new_ext;
  logic signed [SUM_BITS-1:0]    old_ext;

  // Hold off new beats unless the queue is sure to have room for them.
  assign occupancy = {1'b0, q_count} + (QCW + 1)'(a_valid_r);
  assign in_stall  = (occupancy >= (QCW + 1)'(Q_DEPTH));
  assign accept    = in_valid && !in_stall;

  // Ring position, fill state and controller period classification.
  always_comb begin
    wrap      = (pos_r == LAST_POS);
    pos_nxt   = wrap ? '0 : pos_r + 1'b1;
    full_nxt  = full_r || wrap;
    cnt_inc   = {1'b0, cnt_r} + 9'd1;
    hit       = (cnt_inc >= {1'b0, pid_period});
    cnt_nxt   = cnt_r;
    if (full_nxt) begin
      cnt_nxt = hit ? '0 : cnt_inc[7:0];
    end
    flags_nxt.avg_valid = full_nxt;
    flags_nxt.do_pid    = full_nxt && hit;
  end

  // Ring memory: the oldest sample is read out as the new one replaces it.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r       <= ring[pos_r];
      ring[pos_r] <= in_temperature_sample;
    end
  end

  // Payload of the stage that waits for the ring read.
  always_ff @(posedge clk) begin
    if (accept) begin
      new_r   <= in_temperature_sample;
      sub_r   <= full_r;
      flags_r <= flags_nxt;
    end
  end

  // Running sum: add the new sample, drop the oldest once the ring is full.
  always_comb begin
    new_ext  = {{WB{new_r[SAMPLE_BITS-1]}}, new_r};
    old_ext  = {{WB{old_r[SAMPLE_BITS-1]}}, old_r};
    sum_nxt  = sum_r + new_ext - (sub_r ? old_ext : '0);
  end

  assign push       = a_valid_r;
  assign push_sum   = sum_nxt;
  assign push_flags = flags_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      pos_r     <= '0;
      full_r    <= 1'b0;
      cnt_r     <= '0;
      sum_r     <= '0;
    end else begin
      a_valid_r <= accept;
      if (accept) begin
        pos_r  <= pos_nxt;
        full_r <= full_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (a_valid_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

endmodule

[rtl/mapid_queue.sv]
// Short queue that decouples the front end from the back end.
// Depends on mapid_pkg for the default depth.
module mapid_queue
  import mapid_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH,
  localparam int PW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic [CW-1:0]    count
);

  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign pop_data = entries[rd_ptr_r];
  assign count    = count_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/mapid_back.sv]
// Back end: divides the window sum into the average, runs the PID update and
// holds the result beat in the output register. Depends on mapid_pkg.
module mapid_back
  import mapid_pkg::*;
#(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int WB         = $clog2(WINDOW),
  localparam int SUM_BITS   = SAMPLE_BITS + WB,
  localparam int QW         = SUM_BITS + $bits(item_flags_t),
  localparam int QCW        = $clog2(Q_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pid_cfg_t                     pid_cfg,
  input  logic [QCW-1:0]               q_count,
  input  logic [QW-1:0]                q_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_average_valid,
  output logic signed [AVG_BITS-1:0]   out_average_temperature,
  output logic                         out_drive_valid,
  output logic [DRIVE_BITS-1:0]        out_heater_drive
);

  localparam int SB         = SAMPLE_BITS;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (SB + DIV_STEP - 1) / DIV_STEP;
  localparam int E_BITS     = (SB + 2 > 16) ? SB + 2 : 16;
  localparam int ISUM_BITS  = 33;
  localparam int ACC_BITS   = ISUM_BITS + 17;
  localparam int TOT_BITS   = 46;
  localparam int AVG_OUT    = (SB < AVG_BITS) ? SB : AVG_BITS;

  localparam logic [WB:0]         W_TRIAL    = (WB + 1)'(WINDOW);
  localparam logic [SUM_BITS-1:0] DIV_OFFSET = SUM_BITS'(WINDOW) << (SB - 1);
  localparam logic [31:0]         INT_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0]         INT_MIN    = 32'h8000_0000;

  logic                        adv;
  logic [SUM_BITS-1:0]         xoff;
  item_flags_t                 q_flags;

  // Divider pipeline, stage 0 is the load stage.
  logic                        dv_r    [DIV_STAGES+1];
  item_flags_t                 df_r    [DIV_STAGES+1];
  logic [WB-1:0]               rem_r   [DIV_STAGES+1];
  logic [SB-1:0]               quo_r   [DIV_STAGES+1];
  logic [WB-1:0]               rem_nxt [DIV_STAGES];
  logic [SB-1:0]               quo_nxt [DIV_STAGES];

  // PID stage.
  logic signed [SB-1:0]        avg_c;
  logic                        pid_go;
  logic signed [E_BITS-1:0]    e_c;
  logic signed [E_BITS:0]      de_c;
  logic signed [ISUM_BITS-1:0] isum_c;
  logic signed [ACC_BITS-1:0]  acc_c;
  logic signed [ACC_BITS-1:0]  ish_c;
  logic [31:0]                 integ_nxt;
  logic signed [TOT_BITS-1:0]  pe_c;
  logic signed [TOT_BITS-1:0]  dde_c;
  logic signed [31:0]          integ_r;
  logic signed [E_BITS-1:0]    prev_r;

  logic                        p1_v_r;
  item_flags_t                 p1_flags_r;
  logic signed [SB-1:0]        p1_avg_r;
  logic signed [TOT_BITS-1:0]  p1_pe_r;
  logic signed [TOT_BITS-1:0]  p1_dde_r;
  logic signed [31:0]          p1_integ_r;

  // Output stage.
  logic signed [TOT_BITS-1:0]  tot_c;
  logic [DRIVE_BITS-1:0]       drive_c;
  logic                        out_valid_r;
  logic                        out_avg_valid_r;
  logic signed [AVG_BITS-1:0]  out_avg_r;
  logic                        out_drive_valid_r;
  logic [DRIVE_BITS-1:0]       out_drive_r;

  // The whole back end moves together whenever the output slot can take a beat.
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && (q_count != '0);

  // Offset the sum so it is never negative; the quotient's top bit then flips back.
  assign q_flags = item_flags_t'(q_data[QW-1:SUM_BITS]);
  assign xoff    = q_data[SUM_BITS-1:0] + DIV_OFFSET;

  // Restoring division by the window length, a few quotient bits per stage.
  always_comb begin : div_steps
    logic [WB:0]   trial;
    logic [WB-1:0] rem_w;
    logic [SB-1:0] quo_w;
    trial = '0;
    rem_w = '0;
    quo_w = '0;
    for (int g = 0; g < DIV_STAGES; g++) begin
      rem_w = rem_r[g];
      quo_w = quo_r[g];
      for (int k = 0; k < DIV_STEP; k++) begin
        if (g * DIV_STEP + k < SB) begin
          trial = {rem_w, quo_w[SB-1]};
          quo_w = {quo_w[SB-2:0], 1'b0};
          if (trial >= W_TRIAL) begin
            rem_w    = WB'(trial - W_TRIAL);
            quo_w[0] = 1'b1;
          end else begin
            rem_w = trial[WB-1:0];
          end
        end
      end
      rem_nxt[g] = rem_w;
      quo_nxt[g] = quo_w;
    end
  end

  // Error, integral update and the two gain products.
  always_comb begin
    avg_c  = {~quo_r[DIV_STAGES][SB-1], quo_r[DIV_STAGES][SB-2:0]};
    pid_go = dv_r[DIV_STAGES] && df_r[DIV_STAGES].do_pid;
    e_c    = {{(E_BITS - 14){1'b0}}, pid_cfg.setpoint, 6'b0}
           - {{(E_BITS - SB){avg_c[SB-1]}}, avg_c}
           + E_BITS'(MARGIN_UNITS);
    de_c   = {e_c[E_BITS-1], e_c} - {prev_r[E_BITS-1], prev_r};
    isum_c = {integ_r[31], integ_r} + {{(ISUM_BITS - E_BITS){e_c[E_BITS-1]}}, e_c};
    acc_c  = $signed({1'b0, pid_cfg.i_gain}) * isum_c;
    ish_c  = acc_c >>> 12;
    if ((&ish_c[ACC_BITS-1:31]) || !(|ish_c[ACC_BITS-1:31])) begin
      integ_nxt = ish_c[31:0];
    end else begin
      integ_nxt = ish_c[ACC_BITS-1] ? INT_MIN : INT_MAX;
    end
    pe_c   = $signed({1'b0, pid_cfg.p_gain}) * e_c;
    dde_c  = $signed({1'b0, pid_cfg.d_gain}) * de_c;
  end

  // Sum of the three terms, divided by 64 and clamped to the drive range.
  always_comb begin
    tot_c = p1_pe_r + p1_dde_r
          + {{(TOT_BITS - 44){p1_integ_r[31]}}, p1_integ_r, 12'b0};
    if (tot_c[TOT_BITS-1]) begin
      drive_c = '0;
    end else if (|tot_c[TOT_BITS-2:18]) begin
      drive_c = DRIVE_FULL;
    end else begin
      drive_c = {1'b0, tot_c[17:6]};
    end
  end

  // Valid bits and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g <= DIV_STAGES; g++) begin
        dv_r[g] <= 1'b0;
      end
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_r      <= '0;
    end else if (adv) begin
      dv_r[0] <= pop;
      for (int g = 0; g < DIV_STAGES; g++) begin
        dv_r[g+1] <= dv_r[g];
      end
      p1_v_r      <= dv_r[DIV_STAGES];
      out_valid_r <= p1_v_r;
      if (pid_go) begin
        integ_r <= integ_nxt;
        prev_r  <= e_c;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      df_r[0]  <= q_flags;
      rem_r[0] <= xoff[SUM_BITS-1:SB];
      quo_r[0] <= xoff[SB-1:0];
      for (int g = 0; g < DIV_STAGES; g++) begin
        df_r[g+1]  <= df_r[g];
        rem_r[g+1] <= rem_nxt[g];
        quo_r[g+1] <= quo_nxt[g];
      end
      p1_flags_r <= df_r[DIV_STAGES];
      p1_avg_r   <= avg_c;
      p1_pe_r    <= pe_c;
      p1_dde_r   <= dde_c;
      p1_integ_r <= integ_nxt;
      out_avg_valid_r   <= p1_flags_r.avg_valid;
      out_avg_r         <= p1_flags_r.avg_valid ? AVG_BITS'(p1_avg_r[AVG_OUT-1:0]) : '0;
      out_drive_valid_r <= p1_flags_r.do_pid;
      out_drive_r       <= p1_flags_r.do_pid ? drive_c : '0;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_average_valid       = out_avg_valid_r;
  assign out_average_temperature = out_avg_r;
  assign out_drive_valid         = out_drive_valid_r;
  assign out_heater_drive        = out_drive_r;

endmodule

[rtl/moving_average_pid_heater.sv]
// Top level of the moving-average PID heater controller: configuration
// registers, front end, decoupling queue and back end. Depends on mapid_pkg.
//
// One temperature sample (1/64 degC, two's complement) goes in per beat and one
// result beat comes out for it, in order. The block sustains one sample per
// clock while the output is not stalled: the running-sum and integral updates
// are each a combinational update of one register. A sample passes the ring
// read register, the sum update and queue write, the queue read into the
// divider load stage, the divider stages that form the window mean four
// quotient bits at a time, the PID multiply stage and the output register.
// The average is flagged valid from the sample that completes the first fill
// of the WINDOW-entry ring; the heater drive is flagged valid every pid_period
// valid samples after that. A stalled output backs up into the four-entry
// queue before the input is stalled. The ring needs no clearing after reset.
// The user must write configuration only while idle; the block does not check.
module moving_average_pid_heater
  import mapid_pkg::*;
#(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_temperature_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_average_valid,
  output logic signed [AVG_BITS-1:0]    out_average_temperature,
  output logic                          out_drive_valid,
  output logic [DRIVE_BITS-1:0]         out_heater_drive
);

  localparam int WB       = $clog2(WINDOW);
  localparam int SUM_BITS = SAMPLE_BITS + WB;
  localparam int QW       = SUM_BITS + $bits(item_flags_t);
  localparam int QCW      = $clog2(Q_DEPTH + 1);

  logic [7:0]                 setpoint_r;
  logic [15:0]                p_gain_r;
  logic [15:0]                i_gain_r;
  logic [15:0]                d_gain_r;
  logic [7:0]                 pid_period_r;
  pid_cfg_t                   pid_cfg;
  logic                       push;
  logic signed [SUM_BITS-1:0] push_sum;
  item_flags_t                push_flags;
  logic                       pop;
  logic [QW-1:0]              pop_data;
  logic [QCW-1:0]             q_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= RST_SETPOINT;
      p_gain_r     <= RST_P_GAIN;
      i_gain_r     <= RST_I_GAIN;
      d_gain_r     <= RST_D_GAIN;
      pid_period_r <= RST_PID_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETPOINT:   setpoint_r   <= cfg_wdata[7:0];
        CFG_P_GAIN:     p_gain_r     <= cfg_wdata;
        CFG_I_GAIN:     i_gain_r     <= cfg_wdata;
        CFG_D_GAIN:     d_gain_r     <= cfg_wdata;
        CFG_PID_PERIOD: pid_period_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign pid_cfg.setpoint = setpoint_r;
  assign pid_cfg.p_gain   = p_gain_r;
  assign pid_cfg.i_gain   = i_gain_r;
  assign pid_cfg.d_gain   = d_gain_r;

  // Sample intake, ring and running sum.
  mapid_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_temperature_sample (in_temperature_sample),
    .pid_period            (pid_period_r),
    .q_count               (q_count),
    .push                  (push),
    .push_sum              (push_sum),
    .push_flags            (push_flags)
  );

  // Decoupling queue.
  mapid_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_sum}),
    .pop       (pop),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  // Mean, controller and result register.
  mapid_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .pid_cfg                 (pid_cfg),
    .q_count                 (q_count),
    .q_data                  (pop_data),
    .pop                     (pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_average_valid       (out_average_valid),
    .out_average_temperature (out_average_temperature),
    .out_drive_valid         (out_drive_valid),
    .out_heater_drive        (out_heater_drive)
  );

endmodule
